@@ rtl/dtc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dtc_pkg;

  localparam int unsigned WINDOW = 10;
  localparam int unsigned IDX_W  = $clog2(WINDOW);

  localparam int unsigned TICK_W = 32;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned RUN_W  = 20;
  localparam int unsigned PCT_W  = 7;

  // period * limit, then times the window run sum
  localparam int unsigned PL_W   = RUN_W + PCT_W;
  localparam int unsigned WRUN_W = RUN_W + $clog2(WINDOW);
  localparam int unsigned NUM_W  = PL_W + WRUN_W;

  // used ticks never have the top bit set once a backward count is zeroed
  localparam int unsigned USED_W = TICK_W - 1;
  localparam int unsigned TU_W   = USED_W + RUN_W;
  localparam int unsigned DEN_W  = TU_W + PCT_W;

  // one bit more than a run time, so an oversize quotient is still visible
  localparam int unsigned QUO_W  = RUN_W + 1;
  localparam int unsigned HI_W   = NUM_W - QUO_W;
  localparam int unsigned CNT_W  = $clog2(QUO_W + 1);

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [PCT_W-1:0] PCT_FULL   = PCT_W'(100);
  localparam logic [PCT_W-1:0] LIMIT_RST  = PCT_W'(100);
  localparam logic [RUN_W-1:0] PERIOD_RST = RUN_W'(100000);
  localparam logic [RUN_W-1:0] TICK_RST   = RUN_W'(10000);

  typedef enum logic [1:0] {
    REG_LIMIT  = 2'd0,
    REG_PERIOD = 2'd1,
    REG_TICK   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SUM,
    BK_MUL1,
    BK_MUL2,
    BK_DGO,
    BK_DWAIT,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic [TICK_W-1:0] busy_ticks;
    logic [TIME_W-1:0] now_us;
    logic [RUN_W-1:0]  last_run_us;
  } sample_t;

  typedef struct packed {
    logic [RUN_W-1:0] run_us;
    logic [RUN_W-1:0] pause_us;
    logic             pause_enable;
    logic             resume_enable;
    logic             first_sample;
  } result_t;

  typedef struct packed {
    logic [PCT_W-1:0] limit_pct;
    logic [RUN_W-1:0] period_us;
    logic [RUN_W-1:0] tick_us;
  } cfg_t;

  typedef struct packed {
    logic [TICK_W-1:0] busy_ticks;
    logic [RUN_W-1:0]  last_run_us;
    logic [IDX_W-1:0]  newest;
    logic [IDX_W-1:0]  oldest;
    logic              first;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(WINDOW - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dtc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire dtc_pkg::sample_t sample_i,
  input  wire dtc_pkg::q_stat_t q_stat_i,
  output logic                  cmd_push_o,
  output dtc_pkg::cmd_t         cmd_o
);

  logic [dtc_pkg::IDX_W-1:0] newest_q, newest_d;
  logic [dtc_pkg::IDX_W-1:0] oldest_q, oldest_d;
  logic [dtc_pkg::IDX_W-1:0] newest_n;
  logic                      accept;
  logic                      first;
  logic                      win_full;

  assign accept   = push_i && !q_stat_i.full;
  assign newest_n = dtc_pkg::idx_inc(newest_q);
  assign first    = (newest_n == oldest_q);
  // window holds every slot once the slot after newest is the oldest
  assign win_full = (dtc_pkg::idx_inc(newest_n) == oldest_q);

  always_comb begin
    newest_d = newest_q;
    oldest_d = oldest_q;
    if (accept) begin
      newest_d = newest_n;
      if (!first && win_full) begin
        oldest_d = dtc_pkg::idx_inc(oldest_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= dtc_pkg::IDX_W'(dtc_pkg::WINDOW - 1);
      oldest_q <= '0;
    end else begin
      newest_q <= newest_d;
      oldest_q <= oldest_d;
    end
  end

  assign cmd_push_o        = accept;
  assign cmd_o.busy_ticks  = sample_i.busy_ticks;
  assign cmd_o.last_run_us = sample_i.last_run_us;
  assign cmd_o.newest      = newest_n;
  assign cmd_o.oldest      = oldest_q;
  assign cmd_o.first       = first;

endmodule

`default_nettype wire

@@ rtl/dtc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtc_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire dtc_pkg::cmd_t    data_i,
  input  wire logic             pop_i,
  output dtc_pkg::cmd_t         head_o,
  output dtc_pkg::q_stat_t      stat_o
);

  dtc_pkg::cmd_t               slot_q [dtc_pkg::Q_DEPTH];
  logic [dtc_pkg::Q_PTR_W-1:0] wr_q, wr_d;
  logic [dtc_pkg::Q_PTR_W-1:0] rd_q, rd_d;
  logic [dtc_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == dtc_pkg::Q_PTR_W'(dtc_pkg::Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == dtc_pkg::Q_PTR_W'(dtc_pkg::Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  assign head_o       = slot_q[rd_q];
  assign stat_o.full  = (cnt_q == dtc_pkg::Q_CNT_W'(dtc_pkg::Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

@@ rtl/dtc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtc_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [dtc_pkg::NUM_W-1:0] num_i,
  input  wire logic [dtc_pkg::DEN_W-1:0] den_i,
  output logic                           done_o,
  output logic                           sat_o,
  output logic [dtc_pkg::QUO_W-1:0]      quo_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [dtc_pkg::CNT_W-1:0]   cnt_q;
  logic                        sat_q;
  logic [dtc_pkg::DEN_W-1:0]   rem_q;
  logic [dtc_pkg::DEN_W-1:0]   den_q;
  logic [dtc_pkg::QUO_W-1:0]   nlo_q;
  logic [dtc_pkg::QUO_W-1:0]   quo_q;
  logic [dtc_pkg::HI_W-1:0]    hi;
  logic                        sat_start;
  logic [dtc_pkg::DEN_W:0]     trial;
  logic [dtc_pkg::DEN_W:0]     diff;
  logic                        ge;

  // quotient fits in QUO_W bits only when the top part of num is below den
  assign hi        = num_i[dtc_pkg::NUM_W-1:dtc_pkg::QUO_W];
  assign sat_start = (dtc_pkg::DEN_W'(hi) >= den_i);

  assign trial = {rem_q, nlo_q[dtc_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !sat_start;
        done_q <= sat_start;
        cnt_q  <= dtc_pkg::CNT_W'(dtc_pkg::QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == dtc_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sat_q <= sat_start;
      rem_q <= dtc_pkg::DEN_W'(hi);
      den_q <= den_i;
      nlo_q <= num_i[dtc_pkg::QUO_W-1:0];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[dtc_pkg::DEN_W-1:0] : trial[dtc_pkg::DEN_W-1:0];
      nlo_q <= {nlo_q[dtc_pkg::QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[dtc_pkg::QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign sat_o  = sat_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

@@ rtl/dtc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dtc_pkg::cfg_t    cfg_i,
  input  wire dtc_pkg::q_stat_t q_stat_i,
  input  wire dtc_pkg::cmd_t    head_i,
  output logic                  cmd_pop_o,
  input  wire logic             res_pop_i,
  output dtc_pkg::result_t      result_o,
  output logic                  res_valid_o
);

  typedef struct packed {
    logic [dtc_pkg::TICK_W-1:0] tick;
    logic [dtc_pkg::RUN_W-1:0]  run;
  } ring_t;

  ring_t                        ring_q [dtc_pkg::WINDOW];
  ring_t                        rdata_q;

  dtc_pkg::back_state_e         state_q, state_d;
  dtc_pkg::cmd_t                cmd_q;
  logic [dtc_pkg::IDX_W-1:0]    rd_ptr_q;
  logic                         tpend_q, tpend_d;
  logic                         pend_q, pend_d;
  logic [dtc_pkg::WRUN_W-1:0]   wrun_q;
  logic [dtc_pkg::TICK_W-1:0]   used_q;
  logic [dtc_pkg::PL_W-1:0]     prod_pl_q;
  logic [dtc_pkg::TU_W-1:0]     prod_tu_q;
  logic [dtc_pkg::NUM_W-1:0]    num_q;
  logic [dtc_pkg::DEN_W-1:0]    den_q;
  logic [dtc_pkg::RUN_W-1:0]    run_q;
  dtc_pkg::result_t             res_q;
  logic                         res_vld_q, res_vld_d;

  logic                         sum_more;
  logic                         sum_done;
  logic                         zero_used;
  logic [dtc_pkg::RUN_W-1:0]    tick_eff;
  logic [dtc_pkg::DEN_W-1:0]    tu_ext;
  logic                         pop;
  logic                         mem_we;
  logic                         mem_re;
  logic [dtc_pkg::IDX_W-1:0]    mem_raddr;
  logic                         div_start;
  logic                         res_load;
  logic                         div_done;
  logic                         div_sat;
  logic [dtc_pkg::QUO_W-1:0]    div_quo;

  assign sum_more  = (rd_ptr_q != cmd_q.newest);
  assign sum_done  = !sum_more && !pend_q && !tpend_q;
  // a backward tick count reads as no ticks used
  assign zero_used = (used_q == '0) || used_q[dtc_pkg::TICK_W-1];
  assign tick_eff  = (cfg_i.tick_us == '0) ? dtc_pkg::RUN_W'(1) : cfg_i.tick_us;
  assign tu_ext    = dtc_pkg::DEN_W'(prod_tu_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtc_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) begin
          state_d = head_i.first ? dtc_pkg::BK_MUL1 : dtc_pkg::BK_SUM;
        end
      end
      dtc_pkg::BK_SUM: begin
        if (sum_done) begin
          state_d = zero_used ? dtc_pkg::BK_OUT : dtc_pkg::BK_MUL1;
        end
      end
      dtc_pkg::BK_MUL1:  state_d = dtc_pkg::BK_MUL2;
      dtc_pkg::BK_MUL2:  state_d = dtc_pkg::BK_DGO;
      dtc_pkg::BK_DGO:   state_d = dtc_pkg::BK_DWAIT;
      dtc_pkg::BK_DWAIT: begin
        if (div_done) begin
          state_d = dtc_pkg::BK_OUT;
        end
      end
      dtc_pkg::BK_OUT: begin
        if (!res_vld_q || res_pop_i) begin
          state_d = dtc_pkg::BK_IDLE;
        end
      end
      default: state_d = dtc_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = head_i.oldest;
    div_start = 1'b0;
    res_load  = 1'b0;
    unique case (state_q)
      dtc_pkg::BK_IDLE: begin
        pop    = !q_stat_i.empty;
        mem_we = !q_stat_i.empty;
        mem_re = !q_stat_i.empty && !head_i.first;
      end
      dtc_pkg::BK_SUM: begin
        mem_re    = sum_more;
        mem_raddr = rd_ptr_q;
      end
      dtc_pkg::BK_DGO: div_start = 1'b1;
      dtc_pkg::BK_OUT: res_load  = !res_vld_q || res_pop_i;
      default: ;
    endcase
  end

  always_comb begin
    tpend_d   = mem_re && (state_q == dtc_pkg::BK_IDLE);
    pend_d    = mem_re && (state_q == dtc_pkg::BK_SUM);
    res_vld_d = res_vld_q;
    if (res_load) begin
      res_vld_d = 1'b1;
    end else if (res_pop_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dtc_pkg::BK_IDLE;
      tpend_q   <= 1'b0;
      pend_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tpend_q   <= tpend_d;
      pend_q    <= pend_d;
      res_vld_q <= res_vld_d;
    end
  end

  // sample ring
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[head_i.newest] <= '{tick: head_i.busy_ticks, run: head_i.last_run_us};
    end
    if (mem_re) begin
      rdata_q <= ring_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      dtc_pkg::BK_IDLE: begin
        if (pop) begin
          cmd_q    <= head_i;
          rd_ptr_q <= dtc_pkg::idx_inc(head_i.oldest);
          wrun_q   <= dtc_pkg::WRUN_W'(head_i.last_run_us);
        end
      end
      dtc_pkg::BK_SUM: begin
        // first read returns the oldest tick count, the rest are run times
        if (tpend_q) begin
          used_q <= cmd_q.busy_ticks - rdata_q.tick;
        end
        if (pend_q) begin
          wrun_q <= wrun_q + dtc_pkg::WRUN_W'(rdata_q.run);
        end
        if (sum_more) begin
          rd_ptr_q <= dtc_pkg::idx_inc(rd_ptr_q);
        end
        if (sum_done && zero_used) begin
          run_q <= cfg_i.period_us;
        end
      end
      dtc_pkg::BK_MUL1: begin
        prod_pl_q <= dtc_pkg::PL_W'(cfg_i.period_us) * dtc_pkg::PL_W'(cfg_i.limit_pct);
        prod_tu_q <= dtc_pkg::TU_W'(used_q[dtc_pkg::USED_W-1:0]) * dtc_pkg::TU_W'(tick_eff);
      end
      dtc_pkg::BK_MUL2: begin
        if (cmd_q.first) begin
          num_q <= dtc_pkg::NUM_W'(prod_pl_q);
          den_q <= dtc_pkg::DEN_W'(dtc_pkg::PCT_FULL);
        end else begin
          num_q <= dtc_pkg::NUM_W'(prod_pl_q) * dtc_pkg::NUM_W'(wrun_q);
          // times one hundred
          den_q <= (tu_ext << 6) + (tu_ext << 5) + (tu_ext << 2);
        end
      end
      dtc_pkg::BK_DWAIT: begin
        if (div_done) begin
          if (div_sat || (div_quo > dtc_pkg::QUO_W'(cfg_i.period_us))) begin
            run_q <= cfg_i.period_us;
          end else begin
            run_q <= div_quo[dtc_pkg::RUN_W-1:0];
          end
        end
      end
      default: ;
    endcase
    if (res_load) begin
      res_q.run_us        <= run_q;
      res_q.pause_us      <= cfg_i.period_us - run_q;
      res_q.pause_enable  <= (cfg_i.limit_pct < dtc_pkg::PCT_FULL);
      res_q.resume_enable <= (cfg_i.limit_pct != '0) && (cfg_i.limit_pct < dtc_pkg::PCT_FULL);
      res_q.first_sample  <= cmd_q.first;
    end
  end

  dtc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .sat_o   (div_sat),
    .quo_o   (div_quo)
  );

  assign cmd_pop_o   = pop;
  assign result_o    = res_q;
  assign res_valid_o = res_vld_q;

endmodule

`default_nettype wire

@@ rtl/cpu_duty_throttle_controller.sv @@
// Duty-cycle limiter: push one sample per control period (cumulative busy ticks,
// timestamp, last allowed run time) and pop one result (run time, pause time,
// enables, first-sample flag). The timestamp is accepted but does not affect
// any result. Samples go through a two-entry request queue to a sequencer that
// walks the window ring one entry per cycle, forms the quotient with two
// registered multiplier steps and a one-bit-per-cycle divider (QUO_W = 21
// steps). The result register lets the next sample start while a result
// waits to be popped. Registers (limit_pct, period_us, tick_us at byte 0, 4, 8)
// must be written only while no sample is in flight; the block does not
// enforce this. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module cpu_duty_throttle_controller (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire dtc_pkg::sample_t            sample_i,
  output logic                             empty,
  input  wire logic                        pop,
  output dtc_pkg::result_t                 result_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dtc_pkg::APB_AW-1:0]  paddr,
  input  wire logic [dtc_pkg::APB_DW-1:0]  pwdata,
  output logic [dtc_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);

  dtc_pkg::cfg_t    cfg_q, cfg_d;
  dtc_pkg::reg_idx_e reg_idx;
  logic             reg_wr;
  dtc_pkg::q_stat_t q_stat;
  dtc_pkg::cmd_t    cmd_in;
  dtc_pkg::cmd_t    cmd_head;
  logic             cmd_push;
  logic             cmd_pop;
  logic             res_valid;

  assign pready  = 1'b1;
  assign reg_idx = dtc_pkg::reg_idx_e'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (reg_wr) begin
      unique case (reg_idx)
        dtc_pkg::REG_LIMIT:  cfg_d.limit_pct = pwdata[dtc_pkg::PCT_W-1:0];
        dtc_pkg::REG_PERIOD: cfg_d.period_us = pwdata[dtc_pkg::RUN_W-1:0];
        dtc_pkg::REG_TICK:   cfg_d.tick_us   = pwdata[dtc_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dtc_pkg::REG_LIMIT:  prdata = dtc_pkg::APB_DW'(cfg_q.limit_pct);
      dtc_pkg::REG_PERIOD: prdata = dtc_pkg::APB_DW'(cfg_q.period_us);
      dtc_pkg::REG_TICK:   prdata = dtc_pkg::APB_DW'(cfg_q.tick_us);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit_pct <= dtc_pkg::LIMIT_RST;
      cfg_q.period_us <= dtc_pkg::PERIOD_RST;
      cfg_q.tick_us   <= dtc_pkg::TICK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dtc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .sample_i   (sample_i),
    .q_stat_i   (q_stat),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  dtc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .pop_i  (cmd_pop),
    .head_o (cmd_head),
    .stat_o (q_stat)
  );

  dtc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .head_i      (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_pop_i   (pop),
    .result_o    (result_o),
    .res_valid_o (res_valid)
  );

  assign full  = q_stat.full;
  assign empty = !res_valid;

`ifndef SYNTHESIS
  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("request queue both full and empty");

  a_one_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && q_stat.empty) |=> !full)
    else $error("queue full after a single request");

  a_resume_needs_pause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.pause_enable || !result_o.resume_enable))
    else $error("resume enabled without pause");
`endif

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned DRAIN_LIMIT   = 200000;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam logic [dtc_pkg::APB_AW-1:0] UNMAPPED_ADDR = dtc_pkg::APB_AW'(12);

  logic                       clk_i;
  logic                       rst_ni;
  logic                       push;
  logic                       full;
  dtc_pkg::sample_t           sample_i;
  logic                       empty;
  logic                       pop;
  dtc_pkg::result_t           result_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [dtc_pkg::APB_AW-1:0] paddr;
  logic [dtc_pkg::APB_DW-1:0] pwdata;
  logic [dtc_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  cpu_duty_throttle_controller dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .sample_i (sample_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // shadow copy of the limiter state
  dtc_pkg::cfg_t              cfg_shadow;
  logic [dtc_pkg::TICK_W-1:0] win_ticks [dtc_pkg::WINDOW];
  logic [dtc_pkg::RUN_W-1:0]  win_runs [dtc_pkg::WINDOW];
  logic [dtc_pkg::IDX_W-1:0]  head_idx;
  logic [dtc_pkg::IDX_W-1:0]  tail_idx;
  dtc_pkg::result_t           grant_q [$];

  int unsigned error_count = 0;
  int unsigned samples_sent = 0;
  int unsigned grants_checked = 0;
  int unsigned settings_applied = 0;
  int unsigned full_grants = 0;
  int unsigned zero_grants = 0;

  // traffic shaping
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  int unsigned stall_pct = 15;
  int unsigned stall_max = 8;
  int unsigned stall_left = 0;

  logic [dtc_pkg::TICK_W-1:0] tick_acc;
  logic [dtc_pkg::TIME_W-1:0] now_acc;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic dtc_pkg::sample_t mk_sample(input logic [dtc_pkg::TICK_W-1:0] ticks,
                                                 input logic [dtc_pkg::TIME_W-1:0] stamp,
                                                 input logic [dtc_pkg::RUN_W-1:0] ran);
    dtc_pkg::sample_t s;
    s.busy_ticks  = ticks;
    s.now_us      = stamp;
    s.last_run_us = ran;
    return s;
  endfunction

  task automatic grant_for_sample(input dtc_pkg::sample_t s, output dtc_pkg::result_t r);
    logic [63:0]                grant;
    logic [63:0]                num;
    logic [63:0]                den;
    logic [63:0]                wsum;
    logic [63:0]                tick_eff;
    logic [63:0]                period;
    logic [dtc_pkg::TICK_W-1:0] used;
    logic [dtc_pkg::IDX_W-1:0]  k_idx;
    int unsigned                fill;
    head_idx = dtc_pkg::idx_inc(head_idx);
    win_ticks[head_idx] = s.busy_ticks;
    win_runs[head_idx]  = s.last_run_us;
    fill   = (32'(head_idx) + dtc_pkg::WINDOW - 32'(tail_idx)) % dtc_pkg::WINDOW + 1;
    period = 64'(cfg_shadow.period_us);
    if (fill == 1) begin
      grant = period * 64'(cfg_shadow.limit_pct) / 64'(dtc_pkg::PCT_FULL);
    end else begin
      used = win_ticks[head_idx] - win_ticks[tail_idx];
      wsum = '0;
      k_idx = dtc_pkg::idx_inc(tail_idx);
      for (int unsigned k = 1; k < fill; k++) begin
        wsum += 64'(win_runs[k_idx]);
        k_idx = dtc_pkg::idx_inc(k_idx);
      end
      // a tick count that went backwards reads as no busy time
      if (used[dtc_pkg::TICK_W-1]) begin
        used = '0;
      end
      if (used == '0) begin
        grant = period;
      end else begin
        tick_eff = (cfg_shadow.tick_us != '0) ? 64'(cfg_shadow.tick_us) : 64'd1;
        num   = period * 64'(cfg_shadow.limit_pct) * wsum;
        den   = 64'(dtc_pkg::PCT_FULL) * 64'(used) * tick_eff;
        grant = num / den;
      end
      if (fill == dtc_pkg::WINDOW) begin
        tail_idx = dtc_pkg::idx_inc(tail_idx);
      end
    end
    if (grant > period) begin
      grant = period;
    end
    r.run_us        = grant[dtc_pkg::RUN_W-1:0];
    r.pause_us      = dtc_pkg::RUN_W'(period - grant);
    r.pause_enable  = (cfg_shadow.limit_pct < dtc_pkg::PCT_FULL);
    r.resume_enable = (cfg_shadow.limit_pct != '0) &&
                      (cfg_shadow.limit_pct < dtc_pkg::PCT_FULL);
    r.first_sample  = (fill == 1);
  endtask

  task automatic compare_field(input string name, input logic [dtc_pkg::APB_DW-1:0] want,
                               input logic [dtc_pkg::APB_DW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // result side: check each popped grant, then pick the next pop on a stall pattern
  always @(posedge clk_i) begin : grant_check
    dtc_pkg::result_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (grant_q.size() == 0) begin
          $error("grant with no request outstanding: run_us %0d", result_o.run_us);
          error_count++;
        end else begin
          want = grant_q.pop_front();
          grants_checked++;
          if (want.pause_us == '0) full_grants++;
          if (want.run_us == '0) zero_grants++;
          compare_field("run_us", dtc_pkg::APB_DW'(want.run_us),
                        dtc_pkg::APB_DW'(result_o.run_us));
          compare_field("pause_us", dtc_pkg::APB_DW'(want.pause_us),
                        dtc_pkg::APB_DW'(result_o.pause_us));
          compare_field("pause_enable", dtc_pkg::APB_DW'(want.pause_enable),
                        dtc_pkg::APB_DW'(result_o.pause_enable));
          compare_field("resume_enable", dtc_pkg::APB_DW'(want.resume_enable),
                        dtc_pkg::APB_DW'(result_o.resume_enable));
          compare_field("first_sample", dtc_pkg::APB_DW'(want.first_sample),
                        dtc_pkg::APB_DW'(result_o.first_sample));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, stall_max);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end else begin
      pop <= 1'b0;
    end
  end

  task automatic send_sample(input dtc_pkg::sample_t s);
    int unsigned      gap;
    dtc_pkg::result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(0, 30);
        if (gap != 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    burst_left--;
    push     <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (full);
    grant_for_sample(s, r);
    grant_q = {grant_q, r};
    samples_sent++;
  endtask

  // drop push, let every grant come out, then give the sequencer time to settle
  task automatic wait_idle();
    int unsigned n;
    push <= 1'b0;
    n = 0;
    while (grant_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [dtc_pkg::APB_AW-1:0] addr,
                           input logic [dtc_pkg::APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (dtc_pkg::reg_idx_e'(addr[dtc_pkg::APB_AW-1:2]))
      dtc_pkg::REG_LIMIT:  cfg_shadow.limit_pct = data[dtc_pkg::PCT_W-1:0];
      dtc_pkg::REG_PERIOD: cfg_shadow.period_us = data[dtc_pkg::RUN_W-1:0];
      dtc_pkg::REG_TICK:   cfg_shadow.tick_us   = data[dtc_pkg::RUN_W-1:0];
      default: ;
    endcase
    // back to an idle bus cycle
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_reg(input dtc_pkg::reg_idx_e idx);
    logic [dtc_pkg::APB_DW-1:0] want;
    case (idx)
      dtc_pkg::REG_LIMIT:  want = dtc_pkg::APB_DW'(cfg_shadow.limit_pct);
      dtc_pkg::REG_PERIOD: want = dtc_pkg::APB_DW'(cfg_shadow.period_us);
      default:             want = dtc_pkg::APB_DW'(cfg_shadow.tick_us);
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= dtc_pkg::APB_AW'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    compare_field(idx.name(), want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(input logic [dtc_pkg::APB_DW-1:0] limit,
                           input logic [dtc_pkg::APB_DW-1:0] period,
                           input logic [dtc_pkg::APB_DW-1:0] tick);
    wait_idle();
    write_reg(dtc_pkg::APB_AW'({dtc_pkg::REG_LIMIT, 2'b00}), limit);
    write_reg(dtc_pkg::APB_AW'({dtc_pkg::REG_PERIOD, 2'b00}), period);
    write_reg(dtc_pkg::APB_AW'({dtc_pkg::REG_TICK, 2'b00}), tick);
    read_reg(dtc_pkg::REG_LIMIT);
    read_reg(dtc_pkg::REG_PERIOD);
    read_reg(dtc_pkg::REG_TICK);
    settings_applied++;
  endtask

  task automatic test_reset_values();
    read_reg(dtc_pkg::REG_LIMIT);
    read_reg(dtc_pkg::REG_PERIOD);
    read_reg(dtc_pkg::REG_TICK);
  endtask

  task automatic test_first_sample();
    tick_acc = '0;
    send_sample(mk_sample(tick_acc, '0, '0));
  endtask

  // ticks against the oldest entry, which holds zero here
  task automatic test_tick_edges();
    apply_cfg(50, 100000, 10000);
    send_sample(mk_sample(32'd100, '1, dtc_pkg::RUN_W'(100000)));
    send_sample(mk_sample(32'd0, 32'd12345, '1));
    send_sample(mk_sample('1, '0, '0));
    send_sample(mk_sample(32'h7FFF_FFFF, 32'h5555_5555, dtc_pkg::RUN_W'(40000)));
    send_sample(mk_sample(32'h8000_0000, 32'hAAAA_AAAA, dtc_pkg::RUN_W'(1000)));
  endtask

  // a window that holds only zero run times, with the tick count wrapping
  task automatic test_zero_window_run();
    apply_cfg(75, 100000, 10000);
    tick_acc = 32'hFFFF_FFF0;
    for (int i = 0; i < dtc_pkg::WINDOW; i++) begin
      send_sample(mk_sample(tick_acc, 32'(i) * 100000, '0));
      tick_acc += 3;
    end
  endtask

  task automatic test_config_extremes();
    apply_cfg(0, 100000, 10000);
    tick_acc += 5;
    send_sample(mk_sample(tick_acc, $urandom, dtc_pkg::RUN_W'($urandom)));
    apply_cfg(127, 50000, 10000);
    tick_acc += 2;
    send_sample(mk_sample(tick_acc, $urandom, dtc_pkg::RUN_W'($urandom)));
    apply_cfg(1, 1, 1);
    tick_acc += 1;
    send_sample(mk_sample(tick_acc, $urandom, dtc_pkg::RUN_W'($urandom)));
    apply_cfg(50, 0, 10000);
    tick_acc += 7;
    send_sample(mk_sample(tick_acc, $urandom, dtc_pkg::RUN_W'($urandom)));
    apply_cfg(99, 1000000, 0);
    tick_acc += 30;
    send_sample(mk_sample(tick_acc, $urandom, dtc_pkg::RUN_W'($urandom)));
    apply_cfg(99, 32'hF_FFFF, 32'hF_FFFF);
    tick_acc += 1;
    send_sample(mk_sample(tick_acc, $urandom, '1));
    apply_cfg(100, 1000000, 1000000);
    tick_acc += 4;
    send_sample(mk_sample(tick_acc, $urandom, dtc_pkg::RUN_W'($urandom)));
    // a write past the last register must change nothing
    wait_idle();
    write_reg(UNMAPPED_ADDR, $urandom);
    read_reg(dtc_pkg::REG_LIMIT);
    read_reg(dtc_pkg::REG_PERIOD);
    read_reg(dtc_pkg::REG_TICK);
    tick_acc += 9;
    send_sample(mk_sample(tick_acc, $urandom, dtc_pkg::RUN_W'(250000)));
  endtask

  task automatic test_random_traffic();
    logic [dtc_pkg::APB_DW-1:0] limit;
    logic [dtc_pkg::APB_DW-1:0] period;
    logic [dtc_pkg::APB_DW-1:0] tick;
    logic [63:0]                step;
    logic [dtc_pkg::RUN_W-1:0]  ran;
    int unsigned                ran_max;
    int unsigned                tick_eff;
    int unsigned                kind;
    int unsigned                zero_run_pct;
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       limit = 0;
        1:       limit = 100;
        2:       limit = $urandom_range(101, 127);
        3:       limit = 1;
        default: limit = $urandom_range(1, 99);
      endcase
      case ($urandom_range(0, 9))
        0:       period = 0;
        1:       period = 1;
        2:       period = 1000000;
        3:       period = 32'hF_FFFF;
        default: period = $urandom_range(1000, 200000);
      endcase
      case ($urandom_range(0, 9))
        0:       tick = 0;
        1:       tick = 1;
        2:       tick = 1000000;
        3:       tick = 32'hF_FFFF;
        default: tick = $urandom_range(100, 20000);
      endcase
      // stray upper bits now and then, the registers keep only their own width
      if ($urandom_range(0, 3) == 0) limit  |= $urandom & ~32'h7F;
      if ($urandom_range(0, 3) == 0) period |= $urandom & ~32'hF_FFFF;
      if ($urandom_range(0, 3) == 0) tick   |= $urandom & ~32'hF_FFFF;
      apply_cfg(limit, period, tick);

      gaps_on = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 15;
        default: stall_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_max = 2;
        1:       stall_max = 8;
        default: stall_max = 30;
      endcase
      zero_run_pct = ($urandom_range(0, 3) == 0) ? 60 : 3;
      tick_acc = $urandom;
      now_acc  = $urandom;
      ran_max  = (cfg_shadow.period_us != '0) ? 32'(cfg_shadow.period_us) : 32'hF_FFFF;
      tick_eff = (cfg_shadow.tick_us != '0) ? 32'(cfg_shadow.tick_us) : 32'd1;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        kind = $urandom_range(0, 99);
        ran  = ($urandom_range(0, 99) < zero_run_pct) ? '0 :
               dtc_pkg::RUN_W'($urandom_range(0, ran_max));
        if (kind < 80) begin
          // busy ticks roughly in line with the run time, so grants spread out
          step = (64'(ran) / 64'(tick_eff)) * 64'($urandom_range(0, 300)) / 64'd100 +
                 64'($urandom_range(0, 2));
          tick_acc += step[dtc_pkg::TICK_W-1:0];
          now_acc  += 32'(cfg_shadow.period_us) + $urandom_range(0, 500);
          send_sample(mk_sample(tick_acc, now_acc, ran));
        end else if (kind < 88) begin
          send_sample(mk_sample($urandom, $urandom, dtc_pkg::RUN_W'($urandom)));
        end else if (kind < 94) begin
          tick_acc -= $urandom_range(1, 5000);
          send_sample(mk_sample(tick_acc, now_acc, ran));
        end else if (kind < 97) begin
          send_sample(mk_sample(tick_acc, now_acc, ran));
        end else begin
          tick_acc += $urandom;
          send_sample(mk_sample(tick_acc, $urandom, ran));
        end
      end
    end
  endtask

  initial begin
    rst_ni   = 1'b0;
    push     = 1'b0;
    sample_i = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    cfg_shadow.limit_pct = dtc_pkg::LIMIT_RST;
    cfg_shadow.period_us = dtc_pkg::PERIOD_RST;
    cfg_shadow.tick_us   = dtc_pkg::TICK_RST;
    head_idx = dtc_pkg::IDX_W'(dtc_pkg::WINDOW - 1);
    tail_idx = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_first_sample();
    test_tick_edges();
    test_zero_window_run();
    test_config_extremes();
    test_random_traffic();

    wait_idle();
    if (grant_q.size() != 0) begin
      $error("%0d grants never came out", grant_q.size());
      error_count++;
    end
    $display("checked %0d grants from %0d samples over %0d register settings",
             grants_checked, samples_sent, settings_applied);
    $display("full-period grants %0d, zero grants %0d, errors %0d",
             full_grants, zero_grants, error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d grants outstanding", grant_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
